>>> hw/rtl/unsharp_mask_thresholded_defines.svh
// Assertion macros used by the checker file.
`ifndef UNSHARP_MASK_THRESHOLDED_DEFINES_SVH
`define UNSHARP_MASK_THRESHOLDED_DEFINES_SVH

// Property that is also checked while reset is asserted
`define USM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property that is ignored while reset is asserted
`define USM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> hw/rtl/usm_pkg.sv
package usm_pkg;

  // Geometry and kernel limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 7;
  localparam int CHANNELS   = 4;

  localparam int IN_ROWS = MAX_RADIUS + 1;
  localparam int HB_ROWS = 2 * MAX_RADIUS + 1;
  localparam int WIN_LEN = 2 * MAX_RADIUS + 1;

  // Field widths
  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int BLUR_W = 24;
  localparam int RES_W  = 20;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int RAD_W  = 3;
  localparam int CFG_W  = 64;
  localparam int CFG_AW = 6;

  localparam int S_DATA_W = 4 * PIX_W;
  localparam int M_FIELDS_W = COL_W + ROW_W + 4 * RES_W;
  localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  // Derived widths
  localparam int TAP_W    = $clog2(MAX_RADIUS + 1) + 2;
  localparam int OFF_W    = $clog2(MAX_RADIUS + 1);
  localparam int WIN_IW   = $clog2(WIN_LEN);
  localparam int HB_MOD_W = $clog2(HB_ROWS);
  localparam int IN_MOD_W = $clog2(IN_ROWS);
  localparam int HB_AW    = HB_MOD_W + COL_W;
  localparam int IN_AW    = IN_MOD_W + COL_W;
  localparam int HB_DEPTH = HB_ROWS * MAX_WIDTH;
  localparam int IN_DEPTH = IN_ROWS * MAX_WIDTH;
  localparam int ACC_W    = BLUR_W + COEF_W + $clog2(WIN_LEN);

  // Register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BLUR_RADIUS  = 3'd2;
  localparam logic [2:0] REG_COEFF_LOW    = 3'd3;
  localparam logic [2:0] REG_COEFF_HIGH   = 3'd4;
  localparam logic [2:0] REG_THRESHOLD    = 3'd5;
  localparam logic [2:0] REG_GAIN         = 3'd6;

  // Per-tap control that travels down the lane pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic use_mem;
  } lane_ctl_t;

  // Q1.15 coefficient for a tap offset; offsets of eight or more are zero
  function automatic logic [COEF_W-1:0] coef_at(input logic [OFF_W-1:0] off,
                                                input logic [CFG_W-1:0] hi,
                                                input logic [CFG_W-1:0] lo);
    logic [2*CFG_W-1:0] taps;
    taps = {hi, lo};
    if (int'(off) < 8) return taps[int'(off)*COEF_W +: COEF_W];
    else return '0;
  endfunction

  // (sum + 2^14) >> 15, saturated to 24 bits
  function automatic logic [BLUR_W-1:0] round_sat24(input logic [ACC_W-1:0] sum);
    logic [ACC_W:0] rnd;
    logic [ACC_W-15:0] sh;
    rnd = {1'b0, sum} + (ACC_W+1)'(16384);
    sh = rnd[ACC_W:15];
    if (sh > (ACC_W-14)'({BLUR_W{1'b1}})) return '1;
    else return sh[BLUR_W-1:0];
  endfunction

endpackage

>>> hw/rtl/unsharp_mask_thresholded.sv
// A pixel that completes no result leaves the sequencer idle. Otherwise, per
// completed blur column the horizontal taps are issued, drained and written
// to the line store; then per completed output row the vertical taps are
// issued, drained, sharpened and emitted. Taps loop through the shared lane
// multipliers; no new pixel is taken until idle. Reset clears control, counters
// and the tap window; line stores are not cleared and need no clearing pass.
module unsharp_mask_thresholded import usm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // pix_red, pix_green, pix_blue, pix_alpha
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // out_col, out_row, res_red, res_green,
                                         // res_blue, res_alpha, zero pad
  output logic                m_tlast,   // run_last
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]    prdata,
  output logic                pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HISSUE = 3'd1;
  localparam logic [2:0] ST_HDRAIN = 3'd2;
  localparam logic [2:0] ST_HWRITE = 3'd3;
  localparam logic [2:0] ST_VISSUE = 3'd4;
  localparam logic [2:0] ST_VDRAIN = 3'd5;
  localparam logic [2:0] ST_SHARP  = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  function automatic logic [HB_MOD_W-1:0] inc_hb(input logic [HB_MOD_W-1:0] m);
    if (m == HB_MOD_W'(HB_ROWS - 1)) return '0;
    else return m + HB_MOD_W'(1);
  endfunction

  function automatic logic [IN_MOD_W-1:0] inc_in(input logic [IN_MOD_W-1:0] m);
    if (m == IN_MOD_W'(IN_ROWS - 1)) return '0;
    else return m + IN_MOD_W'(1);
  endfunction

  // Configuration registers
  logic [WID_W-1:0] cfg_width;
  logic [HGT_W-1:0] cfg_height;
  logic [RAD_W-1:0] cfg_radius;
  logic [CFG_W-1:0] cfg_coef_lo, cfg_coef_hi;
  logic [PIX_W-1:0] cfg_thresh, cfg_gain;
  logic cfg_wr;

  // Frame position state
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [HB_MOD_W-1:0] row_mod_hb;
  logic [IN_MOD_W-1:0] row_mod_in;
  logic [S_DATA_W-1:0] tap_window [WIN_LEN];
  logic [S_DATA_W-1:0] in_mem [IN_DEPTH];
  logic [S_DATA_W-1:0] inq;

  // Sequencer
  logic [2:0] state;
  logic [COL_W-1:0] cur_c, h_cur, h_hi;
  logic [ROW_W-1:0] cur_y, o_cur, o_lo, o_hi;
  logic o_any;
  logic [HB_MOD_W-1:0] cur_mhb;
  logic [IN_MOD_W-1:0] cur_min;
  logic [RAD_W-1:0] rad;
  logic signed [TAP_W-1:0] tap_r;
  logic drain_cnt;

  // Output register
  logic out_valid, out_last;
  logic [M_DATA_W-1:0] out_data;

  // Effective geometry
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [RAD_W-1:0] r_eff;

  // Accept-time position
  logic accept, wrap_c, row_wrap;
  logic [HGT_W-1:0] y_pre, y_inc2;
  logic [HB_MOD_W-1:0] mhb_pre, acc_mhb;
  logic [IN_MOD_W-1:0] min_pre, acc_min;
  logic [COL_W-1:0] acc_c;
  logic [ROW_W-1:0] acc_y;
  logic [WID_W-1:0] c_inc;
  logic c_last, c_ge_r, y_last, y_ge_r;

  // Tap issue
  logic signed [TAP_W-1:0] rad_s;
  logic [TAP_W-1:0] off_full;
  logic [COEF_W-1:0] coef;
  logic signed [COL_W+1:0] hv;
  logic [COL_W-1:0] hp, hidx;
  logic [S_DATA_W-1:0] hsel;
  logic signed [ROW_W+1:0] ov;
  logic [ROW_W-1:0] vk, ij;
  logic [HB_MOD_W-1:0] vkk;
  logic [HB_MOD_W:0] rmod_w;
  logic [IN_MOD_W-1:0] ijj;
  logic [IN_MOD_W:0] imod_w;
  logic tap_last, more_h, more_o, out_free, emit_load;
  lane_ctl_t lane_ctl;
  logic [HB_AW-1:0] rd_addr, wr_addr;

  logic signed [RES_W-1:0] res [4];

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= WID_W'(640);
      cfg_height <= HGT_W'(480);
      cfg_radius <= RAD_W'(2);
      cfg_coef_lo <= '0;
      cfg_coef_hi <= '0;
      cfg_thresh <= '0;
      cfg_gain <= PIX_W'(256);
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:3])
        REG_FRAME_WIDTH:  cfg_width <= pwdata[WID_W-1:0];
        REG_FRAME_HEIGHT: cfg_height <= pwdata[HGT_W-1:0];
        REG_BLUR_RADIUS:  cfg_radius <= pwdata[RAD_W-1:0];
        REG_COEFF_LOW:    cfg_coef_lo <= pwdata;
        REG_COEFF_HIGH:   cfg_coef_hi <= pwdata;
        REG_THRESHOLD:    cfg_thresh <= pwdata[PIX_W-1:0];
        REG_GAIN:         cfg_gain <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:3])
      REG_FRAME_WIDTH:  prdata = CFG_W'(cfg_width);
      REG_FRAME_HEIGHT: prdata = CFG_W'(cfg_height);
      REG_BLUR_RADIUS:  prdata = CFG_W'(cfg_radius);
      REG_COEFF_LOW:    prdata = cfg_coef_lo;
      REG_COEFF_HIGH:   prdata = cfg_coef_hi;
      REG_THRESHOLD:    prdata = CFG_W'(cfg_thresh);
      REG_GAIN:         prdata = CFG_W'(cfg_gain);
      default:          prdata = '0;
    endcase
  end

  // Clamp geometry
  always_comb begin
    if (cfg_width == '0) w_eff = WID_W'(1);
    else if (cfg_width > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = cfg_width;
    if (cfg_height == '0) h_eff = HGT_W'(1);
    else if (cfg_height > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = cfg_height;
    if (int'(cfg_radius) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
    else r_eff = cfg_radius;
  end

  // Position of the arriving pixel, with wrap for changed geometry
  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    wrap_c = {1'b0, col_count} >= w_eff;
    y_pre = wrap_c ? {1'b0, row_count} + HGT_W'(1) : {1'b0, row_count};
    mhb_pre = wrap_c ? inc_hb(row_mod_hb) : row_mod_hb;
    min_pre = wrap_c ? inc_in(row_mod_in) : row_mod_in;
    row_wrap = y_pre >= h_eff;
    acc_c = wrap_c ? '0 : col_count;
    acc_y = row_wrap ? '0 : y_pre[ROW_W-1:0];
    acc_mhb = row_wrap ? '0 : mhb_pre;
    acc_min = row_wrap ? '0 : min_pre;
    c_inc = {1'b0, acc_c} + WID_W'(1);
    y_inc2 = {1'b0, acc_y} + HGT_W'(1);
    c_last = {1'b0, acc_c} == (w_eff - WID_W'(1));
    c_ge_r = acc_c >= COL_W'(r_eff);
    y_last = {1'b0, acc_y} == (h_eff - HGT_W'(1));
    y_ge_r = acc_y >= ROW_W'(r_eff);
  end

  // Tap window and input line store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN_LEN; k++) tap_window[k] <= '0;
    end else if (accept) begin
      tap_window[0] <= s_tdata;
      for (int k = 1; k < WIN_LEN; k++) tap_window[k] <= tap_window[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mem[{acc_min, acc_c}] <= s_tdata;
    end
    inq <= in_mem[{imod_w[IN_MOD_W-1:0], h_cur}];
  end

  // Tap addressing
  always_comb begin
    rad_s = $signed({{(TAP_W-RAD_W){1'b0}}, rad});
    off_full = (tap_r < 0) ? TAP_W'(-tap_r) : TAP_W'(tap_r);
    coef = coef_at(off_full[OFF_W-1:0], cfg_coef_hi, cfg_coef_lo);
    tap_last = (tap_r == rad_s);

    // Horizontal: clamp column to the row's start and the current column
    hv = $signed({2'b0, h_cur}) + (COL_W+2)'(tap_r);
    if (hv < 0) hp = '0;
    else if (hv > $signed({2'b0, cur_c})) hp = cur_c;
    else hp = hv[COL_W-1:0];
    hidx = cur_c - hp;
    hsel = (hidx < COL_W'(WIN_LEN)) ? tap_window[hidx[WIN_IW-1:0]] : '0;

    // Vertical: rows back from the current one, as a ring offset
    ov = $signed({2'b0, o_cur}) + (ROW_W+2)'(tap_r);
    if (ov < 0) vk = cur_y;
    else if (ov > $signed({2'b0, cur_y})) vk = '0;
    else vk = cur_y - ov[ROW_W-1:0];
    vkk = vk[HB_MOD_W-1:0];
    if (cur_mhb >= vkk) rmod_w = {1'b0, cur_mhb} - {1'b0, vkk};
    else rmod_w = {1'b0, cur_mhb} + (HB_MOD_W+1)'(HB_ROWS) - {1'b0, vkk};
    rd_addr = {rmod_w[HB_MOD_W-1:0], h_cur};
    wr_addr = {cur_mhb, h_cur};

    // Input row of the output pixel
    ij = cur_y - o_cur;
    ijj = ij[IN_MOD_W-1:0];
    if (cur_min >= ijj) imod_w = {1'b0, cur_min} - {1'b0, ijj};
    else imod_w = {1'b0, cur_min} + (IN_MOD_W+1)'(IN_ROWS) - {1'b0, ijj};

    lane_ctl.valid = (state == ST_HISSUE) || (state == ST_VISSUE);
    lane_ctl.first = (tap_r == -rad_s);
    lane_ctl.use_mem = (state == ST_VISSUE);

    more_h = (h_cur != h_hi);
    more_o = (o_cur != o_hi);
    out_free = !out_valid || m_tready;
    emit_load = (state == ST_EMIT) && out_free;
  end

  // Channel lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      logic [BLUR_W-1:0] blur;
      usm_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (lane_ctl),
        .coef    (coef),
        .hsample (hsel[g*PIX_W +: PIX_W]),
        .rd_addr (rd_addr),
        .wr_en   (state == ST_HWRITE),
        .wr_addr (wr_addr),
        .blur    (blur)
      );
      usm_sharp u_sharp (
        .clk    (clk),
        .blur   (blur),
        .inp    (inq[g*PIX_W +: PIX_W]),
        .thresh (cfg_thresh),
        .gain   (cfg_gain),
        .res    (res[g])
      );
    end else begin : g_off
      assign res[g] = '0;
    end
  end

  // Sequencer and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col_count <= '0;
      row_count <= '0;
      row_mod_hb <= '0;
      row_mod_in <= '0;
      drain_cnt <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_c <= acc_c;
            cur_y <= acc_y;
            cur_mhb <= acc_mhb;
            cur_min <= acc_min;
            rad <= r_eff;
            tap_r <= -$signed({{(TAP_W-RAD_W){1'b0}}, r_eff});
            h_cur <= c_ge_r ? acc_c - COL_W'(r_eff) : '0;
            h_hi <= c_last ? acc_c : acc_c - COL_W'(r_eff);
            o_any <= y_last || y_ge_r;
            o_lo <= y_ge_r ? acc_y - ROW_W'(r_eff) : '0;
            o_hi <= y_last ? acc_y : acc_y - ROW_W'(r_eff);
            if (c_last || c_ge_r) state <= ST_HISSUE;
            // advance the frame position
            if (c_inc >= w_eff) begin
              col_count <= '0;
              if (y_inc2 >= h_eff) begin
                row_count <= '0;
                row_mod_hb <= '0;
                row_mod_in <= '0;
              end else begin
                row_count <= y_inc2[ROW_W-1:0];
                row_mod_hb <= inc_hb(acc_mhb);
                row_mod_in <= inc_in(acc_min);
              end
            end else begin
              col_count <= c_inc[COL_W-1:0];
              row_count <= acc_y;
              row_mod_hb <= acc_mhb;
              row_mod_in <= acc_min;
            end
          end
        end
        ST_HISSUE: begin
          if (tap_last) begin
            drain_cnt <= 1'b0;
            state <= ST_HDRAIN;
          end else begin
            tap_r <= tap_r + TAP_W'(1);
          end
        end
        ST_HDRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) state <= ST_HWRITE;
        end
        ST_HWRITE: begin
          tap_r <= -rad_s;
          if (o_any) begin
            o_cur <= o_lo;
            state <= ST_VISSUE;
          end else if (more_h) begin
            h_cur <= h_cur + COL_W'(1);
            state <= ST_HISSUE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_VISSUE: begin
          if (tap_last) begin
            drain_cnt <= 1'b0;
            state <= ST_VDRAIN;
          end else begin
            tap_r <= tap_r + TAP_W'(1);
          end
        end
        ST_VDRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) state <= ST_SHARP;
        end
        ST_SHARP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            tap_r <= -rad_s;
            if (more_o) begin
              o_cur <= o_cur + ROW_W'(1);
              state <= ST_VISSUE;
            end else if (more_h) begin
              h_cur <= h_cur + COL_W'(1);
              state <= ST_HISSUE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data <= M_DATA_W'({res[3], res[2], res[1], res[0], o_cur, h_cur});
      out_last <= !more_o && !more_h;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;
  assign m_tlast = out_last;

endmodule

>>> hw/rtl/usm_lane.sv
// One channel: tap multiply-accumulate shared by both blur passes,
// plus this channel's store of horizontally blurred rows.
module usm_lane import usm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctl_t          ctl,
  input  logic [COEF_W-1:0]  coef,
  input  logic [PIX_W-1:0]   hsample,
  input  logic [HB_AW-1:0]   rd_addr,
  input  logic               wr_en,
  input  logic [HB_AW-1:0]   wr_addr,
  output logic [BLUR_W-1:0]  blur
);

  logic [BLUR_W-1:0] hb_mem [HB_DEPTH];
  logic [BLUR_W-1:0] mem_q;
  lane_ctl_t ctl1, ctl2;
  logic [COEF_W-1:0] coef1;
  logic [PIX_W-1:0] hs1;
  logic [BLUR_W-1:0] opnd;
  logic [BLUR_W+COEF_W-1:0] prod;
  logic [ACC_W-1:0] acc;

  // Line store of horizontal blur results
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hb_mem[wr_addr] <= blur;
    end
    mem_q <= hb_mem[rd_addr];
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else begin
      ctl1 <= ctl;
      ctl2 <= ctl1;
    end
  end

  // Operand stage
  always_ff @(posedge clk) begin
    coef1 <= coef;
    hs1 <= hsample;
  end

  assign opnd = ctl1.use_mem ? mem_q : {{(BLUR_W-PIX_W){1'b0}}, hs1};

  // Product stage
  always_ff @(posedge clk) begin
    prod <= opnd * coef1;
  end

  // Accumulate
  always_ff @(posedge clk) begin
    if (ctl2.valid) begin
      if (ctl2.first) acc <= ACC_W'(prod);
      else acc <= acc + ACC_W'(prod);
    end
  end

  assign blur = round_sat24(acc);

endmodule

>>> hw/rtl/usm_sharp.sv
// Soft-threshold sharpening of one channel.
module usm_sharp import usm_pkg::*; (
  input  logic                    clk,
  input  logic [BLUR_W-1:0]       blur,
  input  logic [PIX_W-1:0]        inp,
  input  logic [PIX_W-1:0]        thresh,
  input  logic [PIX_W-1:0]        gain,
  output logic signed [RES_W-1:0] res
);

  localparam int DW = BLUR_W + 2;

  logic signed [DW-1:0] dt;
  logic [DW-1:0] mag_full;
  logic [2*PIX_W-1:0] prod;
  logic cond_q;
  logic [PIX_W-1:0] inp_q;
  logic [2*PIX_W:0] rnd;
  logic signed [DW-1:0] rr;

  // detail + threshold; negative means the mask applies
  assign dt = $signed({2'b0, blur}) - $signed({{(DW-PIX_W){1'b0}}, inp})
            + $signed({{(DW-PIX_W){1'b0}}, thresh});
  assign mag_full = DW'(-dt);

  always_ff @(posedge clk) begin
    prod <= mag_full[PIX_W-1:0] * gain;
    cond_q <= dt[DW-1];
    inp_q <= inp;
  end

  // Round half away from zero, subtract, saturate
  assign rnd = {1'b0, prod} + (2*PIX_W+1)'(128);
  assign rr = $signed({{(DW-PIX_W){1'b0}}, inp_q})
            - (cond_q ? $signed({1'b0, rnd[2*PIX_W:8]}) : $signed(DW'(0)));

  always_comb begin
    if (rr < $signed(DW'(-524288))) res = {1'b1, {(RES_W-1){1'b0}}};
    else if (rr > $signed(DW'(524287))) res = {1'b0, {(RES_W-1){1'b1}}};
    else res = rr[RES_W-1:0];
  end

endmodule

>>> hw/rtl/usm_checker.sv
`include "unsharp_mask_thresholded_defines.svh"

// Port-level checks on the sharpening block
module usm_props import usm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // No result is pending right after reset
  `USM_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result pending after reset")

  // A stalled result holds its payload
  `USM_ASSERT(a_stall_hold,
              m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
              "stalled result changed")

  // While a pixel still owes results, no new pixel is taken
  `USM_ASSERT(a_busy_no_input, m_tvalid && !m_tlast |-> !s_tready, "input ready while busy")

  // Output data pad bits stay zero
  `USM_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[M_DATA_W-1:M_FIELDS_W] == '0), "nonzero pad")

endmodule

bind unsharp_mask_thresholded usm_props u_usm_props (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
